FILE: hw/rtl/pwmps_pkg.sv
// ----------------------------------------------------------------------------
// PWM phase slot manager package
// Operand widths and the request bundle of the shared multiply-divide unit.
// ----------------------------------------------------------------------------
package pwmps_pkg;

    // Operand A is a period, operand B a phase in 1/16 degree or a whole degree.
    localparam int MULT_A_W = 16;
    localparam int MULT_B_W = 13;
    // The quotient of a 29-bit product divided by 360 or 5760 fits in 21 bits.
    localparam int QUOT_W   = 21;

    typedef struct packed {
        logic start;     // Launch one multiply-divide.
        logic long_div;  // Divide by 5760 when set, by 360 when clear.
    } muldiv_req_t;

endpackage

FILE: hw/rtl/pwmps_muldiv.sv
// ----------------------------------------------------------------------------
// Shared multiply-divide unit
// Computes floor(a*b/360) or floor(a*b/5760) through product, estimate and
// quotient registers, and holds the quotient until the next request completes.
// ----------------------------------------------------------------------------
module pwmps_muldiv import pwmps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  muldiv_req_t          req,
    input  logic [MULT_A_W-1:0]  op_a,
    input  logic [MULT_B_W-1:0]  op_b,
    output logic                 done,
    output logic [QUOT_W-1:0]    quot
);

    localparam int PROD_W      = MULT_A_W + MULT_B_W;
    localparam int X_W         = PROD_W - 3;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 29;
    localparam int MPROD_W     = X_W + RECIP_W;
    // Both divisors are 45 times a power of two, so the power of two is a shift
    // and the 45 is a multiply by a truncated reciprocal.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd45);
    localparam logic [X_W-1:0]     DIV45 = X_W'(45);

    logic                 v1_reg, v2_reg, done_reg;
    logic                 long_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [X_W-1:0]       x_reg;
    logic [MPROD_W-1:0]   mprod_reg;
    logic [QUOT_W-1:0]    quot_reg;

    logic [X_W-1:0]       x_next;
    logic [QUOT_W-1:0]    q0;
    logic [X_W-1:0]       back;
    logic [X_W-1:0]       rem;
    logic [QUOT_W-1:0]    quot_next;

    always_comb begin
        x_next = long_reg ? X_W'(prod_reg >> 7) : X_W'(prod_reg >> 3);
        // The estimate is low by at most one, so one compare corrects it.
        q0        = QUOT_W'(mprod_reg >> RECIP_SHIFT);
        back      = X_W'(q0) * DIV45;
        rem       = x_reg - back;
        quot_next = (rem >= DIV45) ? q0 + QUOT_W'(1) : q0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
        long_reg  <= req.long_div;
        prod_reg  <= PROD_W'(op_a) * PROD_W'(op_b);
        x_reg     <= x_next;
        mprod_reg <= MPROD_W'(x_next) * MPROD_W'(RECIP);
        // The operands may change once a request is launched, so only the
        // quotient of the launched request is captured.
        if (v2_reg) begin
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: hw/rtl/pwm_phase_slot_manager_core.sv
// ----------------------------------------------------------------------------
// PWM phase slot manager
// Keeps timer periods and master compare slots for phase-interleaved timers.
//
//   Channel   Direction  Ports
//   request   in         s_valid s_ready s_kind s_timer_index s_phase_q4
//                        s_new_period
//   result    out        m_valid m_ready m_write_kind m_target_timer
//                        m_target_slot m_write_value m_last
//
// A period request writes the period, then a slot compare for each used slot
// from slot 0 up; a phase request writes the timer's phase compare and, when
// the master period is nonzero, a slot compare and a slot reset. The shared
// multiply-divide unit is used once per compare value.
// Requests with an invalid timer or a zero phase are accepted with no write.
// Synchronous reset clears all periods and slots. A stalled result holds the
// sequencer, while the result register lets the next request in once idle.
// ----------------------------------------------------------------------------
module pwm_phase_slot_manager_core import pwmps_pkg::*; #(
    parameter int NUM_SLOTS   = 4,
    parameter int NUM_TIMERS  = 5,
    parameter int PERIOD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [2:0]  s_timer_index,
    input  logic [12:0] s_phase_q4,
    input  logic [15:0] s_new_period,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_write_kind,
    output logic [2:0]  m_target_timer,
    output logic [1:0]  m_target_slot,
    output logic [15:0] m_write_value,
    output logic        m_last
);

    localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_XW = (SLOT_W > 2) ? SLOT_W : 2;
    localparam int TIMER_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int DEG_W   = 9;

    localparam logic [15:0] PER_MASK =
        (PERIOD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << PERIOD_BITS) - 32'd1);
    localparam logic [QUOT_W-1:0] Q_MAX =
        (PERIOD_BITS >= QUOT_W) ? {QUOT_W{1'b1}}
                                : QUOT_W'((64'd1 << PERIOD_BITS) - 64'd1);
    localparam logic [DEG_W-1:0] DEG_MAX = 9'h1FF;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] WK_PERIOD     = 2'd0;
    localparam logic [1:0] WK_PHASE      = 2'd1;
    localparam logic [1:0] WK_SLOT_CMP   = 2'd2;
    localparam logic [1:0] WK_RESET_SLOT = 2'd3;

    localparam logic KIND_PERIOD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PER_OUT, ST_SCAN, ST_SLOT_WAIT, ST_SLOT_OUT,
        ST_PH_START, ST_PH_WAIT, ST_PH_OUT, ST_PICK, ST_MC_WAIT,
        ST_MC_OUT, ST_RS_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          timer_reg, timer_next;
    logic [12:0]         phase_reg, phase_next;
    logic [SLOT_W-1:0]   slot_idx_reg, slot_idx_next;
    logic [15:0]         master_period_reg, master_period_next;
    logic [15:0]         timer_period_reg [NUM_TIMERS];
    logic [15:0]         timer_period_next [NUM_TIMERS];
    logic [NUM_SLOTS-1:0] slot_used_reg, slot_used_next;
    logic [DEG_W-1:0]    slot_degree_reg [NUM_SLOTS];
    logic [DEG_W-1:0]    slot_degree_next [NUM_SLOTS];

    logic                out_valid_reg, out_valid_next;
    logic [1:0]          out_kind_reg, out_kind_next;
    logic [2:0]          out_timer_reg, out_timer_next;
    logic [1:0]          out_slot_reg, out_slot_next;
    logic [15:0]         out_value_reg, out_value_next;
    logic                out_last_reg, out_last_next;

    muldiv_req_t         md_req;
    logic [MULT_A_W-1:0] md_a;
    logic [MULT_B_W-1:0] md_b;
    logic                md_done;
    logic [QUOT_W-1:0]   md_quot;

    logic                accept;
    logic                out_free;
    logic [15:0]         quot_sat;
    logic [13:0]         deg_sum;
    logic [DEG_W-1:0]    deg_new;
    logic                hit_found, free_found;
    logic [SLOT_W-1:0]   hit_idx, free_idx, pick_idx;
    logic                used_above;
    logic [SLOT_XW-1:0]  slot_wide;
    logic [15:0]         period_in;

    pwmps_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .op_a    (md_a),
        .op_b    (md_b),
        .done    (md_done),
        .quot    (md_quot)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign period_in = s_new_period & PER_MASK;

    // Compare values above the period maximum saturate; the port keeps 16 bits.
    always_comb begin
        logic [QUOT_W-1:0] q;
        q        = (md_quot > Q_MAX) ? Q_MAX : md_quot;
        quot_sat = q[15:0];
    end

    // Round the phase to whole degrees.
    always_comb begin
        deg_sum = {1'b0, phase_reg} + 14'd8;
        deg_new = (deg_sum[13:4] > {1'b0, DEG_MAX}) ? DEG_MAX : deg_sum[12:4];
    end

    // Slot choice: a used slot of the same degree, else the lowest free one,
    // else the last slot is taken over.
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        used_above = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (slot_used_reg[i] && slot_degree_reg[i] == deg_new) begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
            if (!slot_used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
            if (slot_used_reg[i] && i > int'(slot_idx_reg)) begin
                used_above = 1'b1;
            end
        end
        pick_idx = hit_found ? hit_idx : (free_found ? free_idx : SLOT_LAST);
    end

    assign slot_wide = SLOT_XW'(slot_idx_reg);

    always_comb begin
        state_next         = state_reg;
        timer_next         = timer_reg;
        phase_next         = phase_reg;
        slot_idx_next      = slot_idx_reg;
        master_period_next = master_period_reg;
        timer_period_next  = timer_period_reg;
        slot_used_next     = slot_used_reg;
        slot_degree_next   = slot_degree_reg;
        out_valid_next     = out_valid_reg && !m_ready;
        out_kind_next      = out_kind_reg;
        out_timer_next     = out_timer_reg;
        out_slot_next      = out_slot_reg;
        out_value_next     = out_value_reg;
        out_last_next      = out_last_reg;
        md_req.start       = 1'b0;
        md_req.long_div    = 1'b0;
        md_a               = master_period_reg;
        md_b               = MULT_B_W'(slot_degree_reg[slot_idx_reg]);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && 32'(s_timer_index) < NUM_TIMERS) begin
                    timer_next    = s_timer_index;
                    phase_next    = s_phase_q4;
                    slot_idx_next = '0;
                    if (s_kind == KIND_PERIOD) begin
                        master_period_next = period_in;
                        timer_period_next[s_timer_index[TIMER_W-1:0]] = period_in;
                        state_next = ST_PER_OUT;
                    end else if (s_phase_q4 != 13'd0) begin
                        state_next = ST_PH_START;
                    end
                end
            end
            ST_PER_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = WK_PERIOD;
                    out_timer_next = timer_reg;
                    out_slot_next  = 2'd0;
                    out_value_next = master_period_reg;
                    out_last_next  = (slot_used_reg == '0);
                    state_next     = (slot_used_reg == '0) ? ST_IDLE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A used slot is known to exist at or above the index here.
                if (slot_used_reg[slot_idx_reg]) begin
                    md_req.start = 1'b1;
                    state_next   = ST_SLOT_WAIT;
                end else begin
                    slot_idx_next = slot_idx_reg + SLOT_W'(1);
                end
            end
            ST_SLOT_WAIT: begin
                if (md_done) begin
                    state_next = ST_SLOT_OUT;
                end
            end
            ST_SLOT_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = WK_SLOT_CMP;
                    out_timer_next = timer_reg;
                    out_slot_next  = slot_wide[1:0];
                    out_value_next = quot_sat;
                    out_last_next  = !used_above;
                    if (used_above) begin
                        slot_idx_next = slot_idx_reg + SLOT_W'(1);
                        state_next    = ST_SCAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PH_START: begin
                md_req.start    = 1'b1;
                md_req.long_div = 1'b1;
                md_a            = timer_period_reg[timer_reg[TIMER_W-1:0]];
                md_b            = phase_reg;
                state_next      = ST_PH_WAIT;
            end
            ST_PH_WAIT: begin
                if (md_done) begin
                    state_next = ST_PH_OUT;
                end
            end
            ST_PH_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = WK_PHASE;
                    out_timer_next = timer_reg;
                    out_slot_next  = 2'd0;
                    out_value_next = quot_sat;
                    out_last_next  = (master_period_reg == 16'd0);
                    state_next     = (master_period_reg == 16'd0) ? ST_IDLE : ST_PICK;
                end
            end
            ST_PICK: begin
                slot_idx_next              = pick_idx;
                slot_used_next[pick_idx]   = 1'b1;
                slot_degree_next[pick_idx] = deg_new;
                md_req.start               = 1'b1;
                md_b                       = MULT_B_W'(deg_new);
                state_next                 = ST_MC_WAIT;
            end
            ST_MC_WAIT: begin
                if (md_done) begin
                    state_next = ST_MC_OUT;
                end
            end
            ST_MC_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = WK_SLOT_CMP;
                    out_timer_next = timer_reg;
                    out_slot_next  = slot_wide[1:0];
                    out_value_next = quot_sat;
                    out_last_next  = 1'b0;
                    state_next     = ST_RS_OUT;
                end
            end
            ST_RS_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = WK_RESET_SLOT;
                    out_timer_next = timer_reg;
                    out_slot_next  = slot_wide[1:0];
                    out_value_next = 16'(slot_idx_reg);
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            out_valid_reg     <= 1'b0;
            master_period_reg <= '0;
            slot_used_reg     <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                timer_period_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_degree_reg[i] <= '0;
            end
        end else begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            master_period_reg <= master_period_next;
            slot_used_reg     <= slot_used_next;
            timer_period_reg  <= timer_period_next;
            slot_degree_reg   <= slot_degree_next;
        end
        timer_reg     <= timer_next;
        phase_reg     <= phase_next;
        slot_idx_reg  <= slot_idx_next;
        out_kind_reg  <= out_kind_next;
        out_timer_reg <= out_timer_next;
        out_slot_reg  <= out_slot_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_write_kind   = out_kind_reg;
    assign m_target_timer = out_timer_reg;
    assign m_target_slot  = out_slot_reg;
    assign m_write_value  = out_value_reg;
    assign m_last         = out_last_reg;

endmodule

FILE: tb/pwm_phase_slot_manager_checker.sv
// ----------------------------------------------------------------------------
// PWM phase slot manager write checker
// Watches the request and result channels, keeps its own copy of the periods
// and master compare slots, and compares every register write field by field.
// ----------------------------------------------------------------------------
package pwmps_tb_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int NUM_TIMERS = 5;

    typedef enum logic {
        REQ_PHASE  = 1'b0,
        REQ_PERIOD = 1'b1
    } req_kind_e;

    typedef enum logic [1:0] {
        WR_PERIOD     = 2'd0,
        WR_PHASE_CMP  = 2'd1,
        WR_SLOT_CMP   = 2'd2,
        WR_RESET_SLOT = 2'd3
    } write_kind_e;

endpackage

module pwm_phase_slot_manager_checker import pwmps_tb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_kind,
    input  logic [2:0]  s_timer_index,
    input  logic [12:0] s_phase_q4,
    input  logic [15:0] s_new_period,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_write_kind,
    input  logic [2:0]  m_target_timer,
    input  logic [1:0]  m_target_slot,
    input  logic [15:0] m_write_value,
    input  logic        m_last,
    output int          mismatch_count,
    output int          writes_pending
);

    localparam longint unsigned DEG_FULL   = 360;
    localparam longint unsigned PHASE_FULL = 360 * 16;
    localparam logic [8:0]      DEG_MAX    = 9'h1FF;

    typedef struct packed {
        write_kind_e kind;
        logic [2:0]  timer;
        logic [1:0]  slot;
        logic [15:0] value;
        logic        last;
    } reg_write_t;

    reg_write_t  pending_writes[$];

    logic        slot_taken[NUM_SLOTS];
    logic [8:0]  slot_angle[NUM_SLOTS];
    logic [15:0] tmr_period[NUM_TIMERS];
    logic [15:0] mst_period;

    function automatic logic [15:0] saturate(input longint unsigned v);
        return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [15:0] slot_compare(input int s);
        longint unsigned prod;
        prod = mst_period;
        prod = prod * slot_angle[s] / DEG_FULL;
        return saturate(prod);
    endfunction

    // Same degree first, then the first free slot, else the last slot is taken over.
    function automatic int choose_slot(input logic [8:0] deg);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_taken[i] && slot_angle[i] == deg)
                return i;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!slot_taken[i]) begin
                slot_taken[i] = 1'b1;
                slot_angle[i] = deg;
                return i;
            end
        slot_taken[NUM_SLOTS-1] = 1'b1;
        slot_angle[NUM_SLOTS-1] = deg;
        return NUM_SLOTS - 1;
    endfunction

    function automatic void queue_write(input write_kind_e kind, input logic [2:0] t,
                                        input int s, input logic [15:0] value,
                                        input logic last);
        reg_write_t w;
        w.kind  = kind;
        w.timer = t;
        w.slot  = s[1:0];
        w.value = value;
        w.last  = last;
        pending_writes.push_back(w);
    endfunction

    function automatic void predict_register_writes(input logic kind, input logic [2:0] t,
                                                    input logic [12:0] ph,
                                                    input logic [15:0] per);
        int              top_slot;
        int              s;
        longint unsigned prod;
        longint unsigned rounded;
        logic [8:0]      deg;
        if (t >= NUM_TIMERS)
            return;
        if (kind == REQ_PERIOD) begin
            mst_period    = per;
            tmr_period[t] = per;
            top_slot = -1;
            for (s = 0; s < NUM_SLOTS; s++)
                if (slot_taken[s])
                    top_slot = s;
            queue_write(WR_PERIOD, t, 0, per, top_slot < 0);
            for (s = 0; s < NUM_SLOTS; s++)
                if (slot_taken[s])
                    queue_write(WR_SLOT_CMP, t, s, slot_compare(s), s == top_slot);
        end else if (ph != 0) begin
            prod = tmr_period[t];
            prod = prod * ph / PHASE_FULL;
            queue_write(WR_PHASE_CMP, t, 0, saturate(prod), mst_period == 16'd0);
            if (mst_period != 16'd0) begin
                rounded = (longint'(ph) + 8) >> 4;
                deg = (rounded > DEG_MAX) ? DEG_MAX : rounded[8:0];
                s = choose_slot(deg);
                queue_write(WR_SLOT_CMP, t, s, slot_compare(s), 1'b0);
                queue_write(WR_RESET_SLOT, t, s, 16'(s), 1'b1);
            end
        end
    endfunction

    function automatic int field_differs(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : watch
        reg_write_t want_w;
        int         errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_taken[i] = 1'b0;
                slot_angle[i] = '0;
            end
            for (int i = 0; i < NUM_TIMERS; i++)
                tmr_period[i] = '0;
            mst_period = '0;
            pending_writes.delete();
            mismatch_count <= 0;
            writes_pending <= 0;
        end else begin
            // A request cannot produce a write in the cycle it is taken, so
            // predicting first leaves the head of the queue untouched.
            if (s_valid && s_ready)
                predict_register_writes(s_kind, s_timer_index, s_phase_q4, s_new_period);
            if (m_valid && m_ready) begin
                if (pending_writes.size() == 0) begin
                    $error("register write with none expected: kind %0d timer %0d value %0d",
                           m_write_kind, m_target_timer, m_write_value);
                    errs++;
                end else begin
                    want_w = pending_writes.pop_front();
                    errs += field_differs("write_kind", 16'(want_w.kind), 16'(m_write_kind));
                    errs += field_differs("target_timer", 16'(want_w.timer),
                                          16'(m_target_timer));
                    errs += field_differs("target_slot", 16'(want_w.slot), 16'(m_target_slot));
                    errs += field_differs("write_value", want_w.value, m_write_value);
                    errs += field_differs("last", 16'(want_w.last), 16'(m_last));
                end
            end
            mismatch_count <= mismatch_count + errs;
            writes_pending <= pending_writes.size();
        end
    end

endmodule

FILE: tb/pwm_phase_slot_manager_core_tb.sv
// ----------------------------------------------------------------------------
// PWM phase slot manager testbench
// Drives directed and random period and phase requests with random stalls on
// both channels; the write checker predicts and compares every register write.
// ----------------------------------------------------------------------------
module pwm_phase_slot_manager_core_tb import pwmps_tb_pkg::*;;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int ITEMS_PER_RUN = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [2:0]  s_timer_index;
    logic [12:0] s_phase_q4;
    logic [15:0] s_new_period;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_write_kind;
    logic [2:0]  m_target_timer;
    logic [1:0]  m_target_slot;
    logic [15:0] m_write_value;
    logic        m_last;

    int mismatch_count;
    int writes_pending;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    pwm_phase_slot_manager_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_timer_index  (s_timer_index),
        .s_phase_q4     (s_phase_q4),
        .s_new_period   (s_new_period),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_kind   (m_write_kind),
        .m_target_timer (m_target_timer),
        .m_target_slot  (m_target_slot),
        .m_write_value  (m_write_value),
        .m_last         (m_last)
    );

    pwm_phase_slot_manager_checker write_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_timer_index  (s_timer_index),
        .s_phase_q4     (s_phase_q4),
        .s_new_period   (s_new_period),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_kind   (m_write_kind),
        .m_target_timer (m_target_timer),
        .m_target_slot  (m_target_slot),
        .m_write_value  (m_write_value),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .writes_pending (writes_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("pwm_phase_slot_manager_core verification failed");
        $finish;
    end

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_request(input logic kind, input logic [2:0] t,
                                input logic [12:0] ph, input logic [15:0] per);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_timer_index <= t;
        s_phase_q4    <= ph;
        s_new_period  <= per;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Holds the request channel quiet until every predicted write has come back.
    task automatic wait_for_writes;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (writes_pending != 0)
            @(posedge aclk);
    endtask

    // Most phases sit near a few shared degrees so that slots are reused as well
    // as filled and taken over; the rest cover the whole field.
    task automatic random_requests(input int count);
        logic        kind;
        logic [2:0]  t;
        logic [12:0] ph;
        logic [15:0] per;
        int          deg;
        int          sent;
        sent = 0;
        while (sent < count) begin
            kind = ($urandom_range(99) < 25) ? REQ_PERIOD : REQ_PHASE;
            t = ($urandom_range(99) < 8) ? 3'($urandom_range(7, NUM_TIMERS))
                                         : 3'($urandom_range(NUM_TIMERS - 1));
            case ($urandom_range(7))
                0: deg = 0;
                1: deg = 30;
                2: deg = 90;
                3: deg = 180;
                4: deg = 270;
                5: deg = 359;
                6: deg = 511;
                default: deg = $urandom_range(511);
            endcase
            case ($urandom_range(9))
                0: ph = '0;
                1: ph = 13'($urandom_range(8191));
                2: ph = 13'($urandom_range(8191, 5761));
                default: begin
                    if (deg > 0 && $urandom_range(1))
                        ph = 13'(deg * 16 - $urandom_range(8, 1));
                    else
                        ph = 13'(deg * 16 + $urandom_range(7, deg == 0));
                end
            endcase
            case ($urandom_range(7))
                0: per = '0;
                1: per = 16'hFFFF;
                2, 3: per = 16'($urandom_range(255));
                default: per = 16'($urandom_range(65535));
            endcase
            send_request(kind, t, ph, per);
            if (t < NUM_TIMERS && (kind == REQ_PERIOD || ph != 0))
                sent++;
        end
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_kind        <= REQ_PHASE;
        s_timer_index <= '0;
        s_phase_q4    <= '0;
        s_new_period  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With no master period a phase only writes the timer's compare.
        send_request(REQ_PHASE, 3'd0, 13'd1, 16'd0);
        send_request(REQ_PHASE, 3'd1, 13'd0, 16'd0);
        send_request(REQ_PERIOD, 3'd5, 13'd0, 16'd1234);
        send_request(REQ_PHASE, 3'd7, 13'd100, 16'd0);
        send_request(REQ_PERIOD, 3'd0, 13'd0, 16'hFFFF);
        send_request(REQ_PHASE, 3'd0, 13'd2880, 16'd0);
        send_request(REQ_PERIOD, 3'd1, 13'd0, 16'd1000);
        // Largest phase: compare saturates and the degree clips at its maximum.
        send_request(REQ_PHASE, 3'd0, 13'h1FFF, 16'd0);
        send_request(REQ_PHASE, 3'd1, 13'd1440, 16'd0);
        send_request(REQ_PHASE, 3'd2, 13'd1447, 16'd0);
        send_request(REQ_PHASE, 3'd3, 13'd2880, 16'd0);
        send_request(REQ_PHASE, 3'd4, 13'd4320, 16'd0);
        // All slots busy: a new degree takes over the last slot.
        send_request(REQ_PHASE, 3'd2, 13'd5760, 16'd0);
        send_request(REQ_PERIOD, 3'd4, 13'd0, 16'hFFFF);
        send_request(REQ_PHASE, 3'd4, 13'd7, 16'd0);
        send_request(REQ_PHASE, 3'd3, 13'd8, 16'd0);
        send_request(REQ_PERIOD, 3'd3, 13'h1FFF, 16'd0);
        send_request(REQ_PHASE, 3'd3, 13'd100, 16'hFFFF);
        send_request(REQ_PERIOD, 3'd2, 13'd0, 16'd1);
        send_request(REQ_PHASE, 3'd2, 13'd5000, 16'd0);
        send_request(REQ_PERIOD, 3'd4, 13'd0, 16'hAAAA);
        send_request(REQ_PERIOD, 3'd0, 13'd0, 16'h5555);
        wait_for_writes();

        send_idle_pct = 33;
        recv_idle_pct = 59;
        random_requests(ITEMS_PER_RUN);
        wait_for_writes();

        send_idle_pct = 59;
        recv_idle_pct = 33;
        random_requests(ITEMS_PER_RUN);
        wait_for_writes();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_requests(ITEMS_PER_RUN);
        wait_for_writes();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("pwm_phase_slot_manager_core verification clean");
        else
            $display("pwm_phase_slot_manager_core verification failed");
        $finish;
    end

endmodule
